### rtl/assert_macros.svh
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### rtl/btd_pkg.sv
package btd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ANGLE_FRAC_DEF    = 8;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = 33;
  localparam int NORM_W      = 58;
  localparam int XY_W        = 62;
  localparam int MAG_W       = 10;
  localparam int HEAD_W      = 12;
  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_TDATA_W = 16;

  // diff/abs stage plus three normalize stages ahead of the CORDIC;
  // round stage and output stage after it
  localparam int PRE_STAGES  = 4;
  localparam int POST_STAGES = 2;

  localparam int HEAD_UP   = 900;
  localparam int HEAD_HALF = 1800;
  localparam int HEAD_DOWN = 2700;
  localparam int HEAD_FULL = 3600;

  // normalize shift steps, two per stage
  localparam int NORM_STEP [6] = '{32, 16, 8, 4, 2, 1};

  // atan(2^-i) in tenths of a degree, 16 fraction bits
  localparam logic [31:0] ATAN_Q16 [32] = '{
    32'd29491200, 32'd17409672, 32'd9198793, 32'd4669451, 32'd2343786,
    32'd1173036,  32'd586661,   32'd293348,  32'd146676,  32'd73339,
    32'd36669,    32'd18335,    32'd9167,    32'd4584,    32'd2292,
    32'd1146,     32'd573,      32'd286,     32'd143,     32'd72,
    32'd36,       32'd18,       32'd9,       32'd4,       32'd2,
    32'd1,        32'd1,        32'd0,       32'd0,       32'd0,
    32'd0,        32'd0
  };

  typedef struct packed {
    logic dx_zero;
    logic dx_neg;
    logic dy_neg;
    logic dy_zero;
  } btd_meta_t;

  // table angle rounded (halves up) to frac fraction bits
  function automatic logic [31:0] cordic_angle(input int idx, input int frac);
    int          s;
    logic [31:0] t;
    s = 16 - frac;
    t = ATAN_Q16[idx[4:0]];
    if (s <= 0) return t;
    return (t + (32'd1 << (s - 1))) >> s;
  endfunction

endpackage

### rtl/btd_cordic_stage.sv
module btd_cordic_stage #(
  parameter int            XW    = 62,
  parameter int            ZW    = 21,
  parameter int            SHIFT = 0,
  parameter logic [ZW-1:0] ANGLE = '0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [XW-1:0] xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    // y >= 0: rotate clockwise and accumulate the angle
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + $signed(ANGLE);
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - $signed(ANGLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

endmodule

### rtl/bearing_to_destination.sv
// Bearing from a start point to a destination point, 0..3599 tenths of a
// degree counterclockwise from +x.
// Input stream: one transfer carries start_x, start_y, dest_x, dest_y
// (32-bit two's complement each). Output stream: one transfer per input
// carrying the 12-bit heading.
// The datapath is a pipeline of CORDIC_STAGES + 6 register stages: one for
// the 33-bit differences and magnitudes, three for the normalizing shift,
// one per CORDIC iteration, one for clamp and rounding and one output
// register. While m_axis_tready is high, a new item is taken every cycle
// and one heading leaves every cycle.
// Each stage carries its own valid bit and loads whenever it is empty or
// the stage after it moves, so a stalled receiver holds the output
// register while upstream bubbles keep filling; s_axis_tready drops only
// when every stage holds an item and m_axis_tready is low.
// Reset clears the valid bits only; no item is in flight afterward.
`include "assert_macros.svh"

module bearing_to_destination #(
  parameter int CORDIC_STAGES   = btd_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = btd_pkg::ANGLE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x [31:0], start_y [63:32], dest_x [95:64], dest_y [127:96]
  input  logic [btd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // heading [11:0], zero [15:12]
  output logic [btd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import btd_pkg::*;

  localparam int N   = CORDIC_STAGES;
  localparam int L   = PRE_STAGES + N + POST_STAGES;
  localparam int ZW  = 13 + ANGLE_FRAC_BITS;
  localparam int RND = PRE_STAGES + N;
  localparam int OUTS = RND + 1;
  localparam logic signed [ZW-1:0] Z_FULL = ZW'(HEAD_UP << ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(1 << (ANGLE_FRAC_BITS - 1));

  logic [L-1:0] v, en;
  btd_meta_t    meta [0:L-1];

  // stage advance: empty, or some later stage empty, or receiver ready
  always_comb begin
    for (int k = 0; k < L; k++) begin
      en[k] = m_axis_tready || (((~v) >> k) != '0);
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_axis_tvalid;
      for (int k = 1; k < L; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ---- stage 0: differences and magnitudes ----
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ax_next, ay_next, ax, ay;
  btd_meta_t                meta0_next;

  always_comb begin
    dx = $signed({s_axis_tdata[3*COORD_W-1], s_axis_tdata[3*COORD_W-1:2*COORD_W]})
       - $signed({s_axis_tdata[COORD_W-1], s_axis_tdata[COORD_W-1:0]});
    dy = $signed({s_axis_tdata[4*COORD_W-1], s_axis_tdata[4*COORD_W-1:3*COORD_W]})
       - $signed({s_axis_tdata[2*COORD_W-1], s_axis_tdata[2*COORD_W-1:COORD_W]});
    ax_next = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay_next = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    meta0_next.dx_zero = (dx == '0);
    meta0_next.dx_neg  = dx[DIFF_W-1];
    meta0_next.dy_neg  = dy[DIFF_W-1];
    meta0_next.dy_zero = (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax <= ax_next;
      ay <= ay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) meta[0] <= meta0_next;
    for (int k = 1; k < L; k++) begin
      if (en[k]) meta[k] <= meta[k-1];
    end
  end

  // ---- stages 1..3: shift both parts until bit 57 of the larger is set ----
  logic [NORM_W-1:0] na [0:3];
  logic [NORM_W-1:0] nb [0:3];

  assign na[0] = NORM_W'(ax);
  assign nb[0] = NORM_W'(ay);

  for (genvar g = 0; g < 3; g++) begin : g_norm
    logic [NORM_W-1:0] a_next, b_next;

    always_comb begin
      a_next = na[g];
      b_next = nb[g];
      for (int j = 0; j < 2; j++) begin
        // the OR has the same leading zeros as the larger part
        if (((a_next | b_next) >> (NORM_W - NORM_STEP[2*g+j])) == '0) begin
          a_next = a_next << NORM_STEP[2*g+j];
          b_next = b_next << NORM_STEP[2*g+j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[1+g]) begin
        na[g+1] <= a_next;
        nb[g+1] <= b_next;
      end
    end
  end

  // ---- CORDIC iterations, one stage each ----
  logic signed [XY_W-1:0] cx [0:N];
  logic signed [XY_W-1:0] cy [0:N];
  logic signed [ZW-1:0]   cz [0:N];

  assign cx[0] = $signed({{(XY_W-NORM_W){1'b0}}, na[3]});
  assign cy[0] = $signed({{(XY_W-NORM_W){1'b0}}, nb[3]});
  assign cz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    btd_cordic_stage #(
      .XW    (XY_W),
      .ZW    (ZW),
      .SHIFT (i),
      .ANGLE (ZW'(cordic_angle(i, ANGLE_FRAC_BITS)))
    ) u_stage (
      .clk   (clk),
      .en    (en[PRE_STAGES+i]),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );
  end

  // ---- clamp to [0, 90 deg] and round to tenths ----
  logic signed [ZW-1:0] zc, zsum;
  logic [MAG_W-1:0]     mag_next, mag;

  always_comb begin
    if (cz[N] < 0)           zc = '0;
    else if (cz[N] > Z_FULL) zc = Z_FULL;
    else                     zc = cz[N];
    zsum     = zc + Z_HALF;
    mag_next = MAG_W'(zsum >>> ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[RND]) mag <= mag_next;
  end

  // ---- quadrant and vertical-line handling ----
  logic [HEAD_W-1:0] heading_next, heading;
  btd_meta_t         mq;

  always_comb begin
    mq = meta[RND];
    if (mq.dx_zero) begin
      if (mq.dy_zero)     heading_next = '0;
      else if (mq.dy_neg) heading_next = HEAD_W'(HEAD_DOWN);
      else                heading_next = HEAD_W'(HEAD_UP);
    end else if (mq.dx_neg) begin
      if (mq.dy_neg) heading_next = HEAD_W'(HEAD_HALF) + HEAD_W'(mag);
      else           heading_next = HEAD_W'(HEAD_HALF) - HEAD_W'(mag);
    end else if (mq.dy_neg && mag != '0) begin
      heading_next = HEAD_W'(HEAD_FULL) - HEAD_W'(mag);
    end else begin
      heading_next = HEAD_W'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) heading <= heading_next;
  end

  assign m_axis_tvalid = v[L-1];
  assign m_axis_tdata  = OUT_TDATA_W'(heading);

  `ASSERT_PROP(a_heading_range, clk, rst, m_axis_tvalid |-> (heading < HEAD_W'(HEAD_FULL)), "heading out of range")
  `ASSERT_PROP(a_stall_only_full, clk, rst, !s_axis_tready |-> ((&v) && !m_axis_tready), "input stalled with a free stage")
  `ASSERT_PROP(a_vertical, clk, rst, (m_axis_tvalid && meta[L-1].dx_zero) |-> (heading == '0 || heading == HEAD_W'(HEAD_UP) || heading == HEAD_W'(HEAD_DOWN)), "vertical line heading wrong")

endmodule
